/* design/gh_pkg.sv */
// Shared constants and types for the greedy hypothesis selector.
`default_nettype none
package gh_pkg;

  localparam int unsigned NodesDef  = 32;
  localparam int unsigned FramesDef = 16;
  localparam int unsigned MaxOut    = 32;

  localparam int unsigned IdW       = 16;
  localparam int unsigned ScoreW    = 16;
  localparam int unsigned DetW      = 11;
  localparam int unsigned NodeIdxW  = 5;

  // Detection codes that mean "no detection"
  localparam logic [DetW-1:0] DetNone = 11'h000;
  localparam logic [DetW-1:0] DetNeg1 = 11'h7FF;

  // Load-side commands from the sequencer to the conflict builder
  typedef struct packed {
    logic rd;   // entry accepted with a hypothesis slot and a frame slot: fetch its frame word
    logic clr;  // end of set: wipe the conflict matrix
  } gh_ctl_t;

endpackage
`default_nettype wire

/* design/gh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read ports; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/gh_conflict.sv */
// Path memory and conflict matrix builder: one read-modify-write per entry.
`default_nettype none
module gh_conflict #(
  parameter int unsigned NODES  = gh_pkg::NodesDef,
  parameter int unsigned FRAMES = gh_pkg::FramesDef,
  parameter int unsigned IdxW   = (NODES > 1) ? $clog2(NODES) : 1,
  parameter int unsigned FpW    = $clog2(FRAMES + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gh_pkg::gh_ctl_t         ctl_i,
  input  wire logic [IdxW-1:0]         h_i,
  input  wire logic [FpW-1:0]          fp_i,
  input  wire logic [gh_pkg::DetW-1:0] det_i,
  input  wire logic [IdxW-1:0]         row_sel_i,
  output logic      [NODES-1:0]        row_o
);
  import gh_pkg::*;

  localparam int unsigned PaW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned WordW = NODES * DetW;

  logic                 pend_q;
  logic [IdxW-1:0]      h_q;
  logic [FpW-1:0]       fp_q;
  logic [DetW-1:0]      det_q;
  logic [FpW-1:0]       plen_q [NODES];
  logic [NODES-1:0]     conf_q [NODES];
  logic [WordW-1:0]     word_rd;
  logic [WordW-1:0]     word_wr;
  logic [NODES-1:0]     hit;
  logic                 det_real;

  // One word per frame position, one lane per hypothesis
  gh_ram #(.Width(WordW), .Depth(FRAMES)) u_path (
    .clk_i   (clk_i),
    .we_i    (pend_q),
    .waddr_i (fp_q[PaW-1:0]),
    .wdata_i (word_wr),
    .re_i    (ctl_i.rd),
    .raddr_i (fp_i[PaW-1:0]),
    .rdata_o (word_rd)
  );

  // Compare the new detection against earlier hypotheses at this frame
  always_comb begin
    det_real = (det_q != DetNone) && (det_q != DetNeg1);
    for (int j = 0; j < NODES; j++) begin
      hit[j] = det_real && (IdxW'(j) < h_q) && (fp_q < plen_q[j]) &&
               (word_rd[j*DetW +: DetW] == det_q);
      word_wr[j*DetW +: DetW] = (IdxW'(j) == h_q) ? det_q : word_rd[j*DetW +: DetW];
    end
  end

  // Hold the entry, then write back its lane and record conflicts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      for (int k = 0; k < NODES; k++) begin
        plen_q[k] <= '0;
        conf_q[k] <= '0;
      end
    end else begin
      pend_q <= ctl_i.rd;
      if (ctl_i.rd) begin
        h_q   <= h_i;
        fp_q  <= fp_i;
        det_q <= det_i;
      end
      if (ctl_i.clr) begin
        for (int k = 0; k < NODES; k++) begin
          plen_q[k] <= '0;
          conf_q[k] <= '0;
        end
      end else if (pend_q) begin
        plen_q[h_q] <= fp_q + FpW'(1);
        for (int k = 0; k < NODES; k++) begin
          if (IdxW'(k) == h_q) begin
            conf_q[k] <= conf_q[k] | hit;
          end else if (hit[k]) begin
            conf_q[k][h_q] <= 1'b1;
          end
        end
      end
    end
  end

  assign row_o = conf_q[row_sel_i];

endmodule
`default_nettype wire

/* design/greedy_hypothesis_selector.sv */
// Top level: entry loading, greedy selection sequencer and result output.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | hyp_id, score, detection, last flags
//  out     | output    | out_valid_o/out_ready_i| pick_pos, chosen_id, last_chosen,
//          |           |                        | overflow
//
// For each path entry the frame word of the path memory is read, compared
// lane by lane and written back. After the final entry the greedy pass
// runs: each hypothesis is visited in order, a live one reading the score
// memory per candidate and a removed one being skipped; each result then
// passes the emit and output steps and waits out any output stall. Input is
// not taken during selection. Reset clears control state and the conflict
// matrix only; no clearing pass.
`default_nettype none
module greedy_hypothesis_selector #(
  parameter int unsigned NODES  = gh_pkg::NodesDef,
  parameter int unsigned FRAMES = gh_pkg::FramesDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gh_pkg::IdW-1:0]      hyp_id_i,
  input  wire logic signed [gh_pkg::ScoreW-1:0] score_i,
  input  wire logic signed [gh_pkg::DetW-1:0]   detection_i,
  input  wire logic                        last_in_path_i,
  input  wire logic                        last_hypothesis_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [gh_pkg::NodeIdxW-1:0] pick_pos_o,
  output logic      [gh_pkg::IdW-1:0]      chosen_id_o,
  output logic                             last_chosen_o,
  output logic                             overflow_o
);
  import gh_pkg::*;

  localparam int unsigned IdxW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CntW = $clog2(NODES + 1);
  localparam int unsigned FpW  = $clog2(FRAMES + 1);
  localparam int unsigned OcW  = $clog2(MaxOut + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_UPD, S_ROW, S_BEST, S_RDJ, S_CMPJ, S_APPLY, S_NEXT, S_EMIT, S_OUT
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         hc_q;
  logic [FpW-1:0]          fp_q;
  logic                    lost_q;
  logic                    end_all_q;
  logic [NODES-1:0]        alive_q;
  logic [NODES-1:0]        neb_q;
  logic [IdxW-1:0]         i_q, j_q, win_q, pend_q, emit_idx_q;
  logic                    pend_valid_q, emit_last_q, stop_q;
  logic [OcW-1:0]          cnt_q;
  logic signed [ScoreW-1:0] best_q;
  logic                    out_valid_q, last_q, ovf_q;
  logic [IdxW-1:0]         idx_out_q;
  logic [IdW-1:0]          id_out_q;

  logic                    accept, has_slot, has_frame, out_free;
  logic                    last_i, last_j;
  logic [NODES-1:0]        alive_init, bit_i, bit_win, row;
  logic [IdxW-1:0]         row_sel, score_raddr;
  logic                    score_re;
  logic [ScoreW-1:0]       score_rd;
  logic [IdW-1:0]          id_rd;
  gh_ctl_t                 ctl;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign has_slot   = hc_q < CntW'(NODES);
  assign has_frame  = fp_q < FpW'(FRAMES);
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_i     = (CntW'(i_q) + CntW'(1)) == hc_q;
  assign last_j     = (CntW'(j_q) + CntW'(1)) == hc_q;

  // Decode memory and matrix access for the current step
  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      alive_init[k] = CntW'(k) < hc_q;
    end
    bit_i       = NODES'(1) << i_q;
    bit_win     = NODES'(1) << win_q;
    row_sel     = (state_q == S_APPLY) ? win_q : i_q;
    score_re    = ((state_q == S_ROW) && alive_q[i_q]) ||
                  ((state_q == S_RDJ) && neb_q[j_q]);
    score_raddr = (state_q == S_ROW) ? i_q : j_q;
    ctl.rd      = accept && has_slot && has_frame;
    ctl.clr     = (state_q == S_OUT) && out_free && emit_last_q;
  end

  gh_conflict #(.NODES(NODES), .FRAMES(FRAMES)) u_conflict (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .h_i       (hc_q[IdxW-1:0]),
    .fp_i      (fp_q),
    .det_i     (detection_i),
    .row_sel_i (row_sel),
    .row_o     (row)
  );

  gh_ram #(.Width(ScoreW), .Depth(NODES)) u_score (
    .clk_i   (clk_i),
    .we_i    (accept && has_slot),
    .waddr_i (hc_q[IdxW-1:0]),
    .wdata_i (score_i),
    .re_i    (score_re),
    .raddr_i (score_raddr),
    .rdata_o (score_rd)
  );

  gh_ram #(.Width(IdW), .Depth(NODES)) u_id (
    .clk_i   (clk_i),
    .we_i    (accept && has_slot),
    .waddr_i (hc_q[IdxW-1:0]),
    .wdata_i (hyp_id_i),
    .re_i    (state_q == S_EMIT),
    .raddr_i (emit_idx_q),
    .rdata_o (id_rd)
  );

  // Sequencer: load entries, run the greedy pass, emit picks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      hc_q         <= '0;
      fp_q         <= '0;
      lost_q       <= 1'b0;
      end_all_q    <= 1'b0;
      alive_q      <= '0;
      neb_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      win_q        <= '0;
      pend_q       <= '0;
      emit_idx_q   <= '0;
      pend_valid_q <= 1'b0;
      emit_last_q  <= 1'b0;
      stop_q       <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            end_all_q <= last_hypothesis_i;
            if (!has_slot || !has_frame) begin
              lost_q <= 1'b1;
            end
            if (last_in_path_i || last_hypothesis_i) begin
              fp_q <= '0;
              if (has_slot) begin
                hc_q <= hc_q + CntW'(1);
              end
            end else if (has_frame) begin
              fp_q <= fp_q + FpW'(1);
            end
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (end_all_q) begin
            alive_q      <= alive_init;
            i_q          <= '0;
            cnt_q        <= '0;
            stop_q       <= 1'b0;
            pend_valid_q <= 1'b0;
            state_q      <= S_ROW;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_ROW: begin
          neb_q <= alive_q & row & ~bit_i;
          state_q <= alive_q[i_q] ? S_BEST : S_NEXT;
        end
        S_BEST: begin
          best_q  <= score_rd;
          win_q   <= i_q;
          j_q     <= '0;
          state_q <= S_RDJ;
        end
        S_RDJ: begin
          if (neb_q[j_q]) begin
            state_q <= S_CMPJ;
          end else if (last_j) begin
            state_q <= S_APPLY;
          end else begin
            j_q <= j_q + IdxW'(1);
          end
        end
        S_CMPJ: begin
          if ($signed(score_rd) > best_q) begin
            best_q <= score_rd;
            win_q  <= j_q;
          end
          if (last_j) begin
            state_q <= S_APPLY;
          end else begin
            j_q     <= j_q + IdxW'(1);
            state_q <= S_RDJ;
          end
        end
        S_APPLY: begin
          if (win_q == i_q) begin
            alive_q <= alive_q & ~bit_i & ~neb_q;
          end else begin
            alive_q <= alive_q & ~bit_i & ~bit_win & ~(neb_q & row);
          end
          cnt_q <= cnt_q + OcW'(1);
          if ((cnt_q + OcW'(1)) == OcW'(MaxOut)) begin
            stop_q <= 1'b1;
          end
          pend_q       <= win_q;
          pend_valid_q <= 1'b1;
          if (pend_valid_q) begin
            emit_idx_q  <= pend_q;
            emit_last_q <= 1'b0;
            state_q     <= S_EMIT;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (stop_q || last_i) begin
            emit_idx_q  <= pend_q;
            emit_last_q <= 1'b1;
            state_q     <= S_EMIT;
          end else begin
            i_q     <= i_q + IdxW'(1);
            state_q <= S_ROW;
          end
        end
        S_EMIT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            idx_out_q   <= emit_idx_q;
            id_out_q    <= id_rd;
            last_q      <= emit_last_q;
            ovf_q       <= lost_q;
            if (emit_last_q) begin
              hc_q    <= '0;
              fp_q    <= '0;
              lost_q  <= 1'b0;
              alive_q <= '0;
              state_q <= S_LOAD;
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pick_pos_o    = NodeIdxW'(idx_out_q);
  assign chosen_id_o   = id_out_q;
  assign last_chosen_o = last_q;
  assign overflow_o    = ovf_q;

  // Write-back step always follows an accepted entry
  a_upd_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(accept))
    else $error("path update without accepted entry");

  // No hypothesis stays live between sets
  a_alive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> alive_q == '0)
    else $error("live hypotheses while loading");

  // Result count stays within the limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OcW'(MaxOut))
    else $error("too many results");

  // A result is never loaded over one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> state_q == S_OUT)
    else $error("result overwritten");

  // Hypothesis count never passes capacity
  a_hc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= CntW'(NODES))
    else $error("hypothesis count over capacity");

endmodule
`default_nettype wire

/* dv/greedy_hypothesis_selector_tb.sv */
// Testbench for the greedy hypothesis selector: directed, overflow, back-pressure and random hypothesis sets.
`timescale 1ns / 100ps
`default_nettype none
module greedy_hypothesis_selector_tb;
  import gh_pkg::*;

  localparam int unsigned Nodes  = NodesDef;
  localparam int unsigned Frames = FramesDef;

  typedef struct packed {
    logic [NodeIdxW-1:0] node;
    logic [IdW-1:0]      id;
    logic                last;
    logic                ovf;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [IdW-1:0] hyp_id_i = '0;
  logic signed [ScoreW-1:0] score_i = '0;
  logic signed [DetW-1:0] detection_i = '0;
  logic last_in_path_i = 1'b0;
  logic last_hypothesis_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [NodeIdxW-1:0] pick_pos_o;
  logic [IdW-1:0] chosen_id_o;
  logic last_chosen_o;
  logic overflow_o;

  greedy_hypothesis_selector uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .hyp_id_i, .score_i, .detection_i,
    .last_in_path_i, .last_hypothesis_i, .out_valid_o, .out_ready_i, .pick_pos_o,
    .chosen_id_o, .last_chosen_o, .overflow_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [DetW-1:0]   det_mem [Nodes][Frames];
  logic [ScoreW-1:0] score_mem [Nodes];
  logic [IdW-1:0]    id_mem [Nodes];
  logic [Nodes-1:0]  conflict_row [Nodes];
  int unsigned       n_hyps;
  int unsigned       frame_ix;
  bit                dropped;

  pick_t picks_due[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void clear_set();
    for (int k = 0; k < Nodes; k++) conflict_row[k] = '0;
    n_hyps = 0;
    frame_ix = 0;
    dropped = 1'b0;
  endfunction

  // Greedy pass over the loaded set; queue the selected hypotheses
  function automatic void select_set();
    int unsigned n;
    int unsigned cnt;
    int unsigned chosen [$];
    logic [Nodes-1:0] alive;
    logic [Nodes-1:0] nbr;
    int unsigned win;
    pick_t p;
    n = (n_hyps > Nodes) ? Nodes : n_hyps;
    alive = '0;
    for (int k = 0; k < n; k++) alive[k] = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!alive[i]) continue;
      nbr = alive & conflict_row[i];
      nbr[i] = 1'b0;
      win = i;
      for (int j = 0; j < n; j++) begin
        if (nbr[j] && $signed(score_mem[j]) > $signed(score_mem[win])) win = j;
      end
      alive[i] = 1'b0;
      if (win == i) begin
        alive &= ~nbr;
      end else begin
        alive[win] = 1'b0;
        alive &= ~(nbr & conflict_row[win]);
      end
      chosen.insert(chosen.size(), win);
    end
    cnt = (chosen.size() > MaxOut) ? MaxOut : chosen.size();
    for (int k = 0; k < cnt; k++) begin
      p.node = NodeIdxW'(chosen[k]);
      p.id = id_mem[chosen[k]];
      p.last = (k + 1 == cnt);
      p.ovf = dropped;
      picks_due.insert(picks_due.size(), p);
    end
    clear_set();
  endfunction

  // Absorb one path entry into the predictor
  function automatic void load_entry(input logic [IdW-1:0] id, input logic [ScoreW-1:0] sc,
                                     input logic [DetW-1:0] det, input bit lp, input bit lh);
    int unsigned h;
    h = n_hyps;
    if (h < Nodes) begin
      if (frame_ix == 0) for (int f = 0; f < Frames; f++) det_mem[h][f] = DetNone;
      score_mem[h] = sc;
      id_mem[h] = id;
      if (frame_ix < Frames) begin
        det_mem[h][frame_ix] = det;
        if (det != DetNone && det != DetNeg1) begin
          for (int j = 0; j < h; j++) begin
            if (det_mem[j][frame_ix] == det) begin
              conflict_row[h][j] = 1'b1;
              conflict_row[j][h] = 1'b1;
            end
          end
        end
      end else begin
        dropped = 1'b1;
      end
    end else begin
      dropped = 1'b1;
    end
    if (lp || lh) begin
      if (n_hyps < Nodes) n_hyps++;
      frame_ix = 0;
    end else if (frame_ix < Frames) begin
      frame_ix++;
    end
    if (lh) select_set();
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_entry(input logic [IdW-1:0] id, input logic [ScoreW-1:0] sc,
                            input logic [DetW-1:0] det, input bit lp, input bit lh);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hyp_id_i <= id;
    score_i <= sc;
    detection_i <= det;
    last_in_path_i <= lp;
    last_hypothesis_i <= lh;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    load_entry(id, sc, det, lp, lh);
  endtask

  task automatic send_hyp(input logic [IdW-1:0] id, input logic [ScoreW-1:0] sc,
                          input int unsigned len, input int unsigned det_range,
                          input bit final_one);
    for (int f = 0; f < len; f++) begin
      send_entry(id, sc, DetW'($urandom_range(det_range)), f == len - 1,
                 final_one && f == len - 1);
    end
  endtask

  // Drop the input and wait for all expected results
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall, check each result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (picks_due.size() == 0) begin
          report("result with nothing expected");
        end else begin
          pick_t p;
          p = picks_due.pop_front();
          if (pick_pos_o !== p.node)
            report($sformatf("pick_pos %0d, expected %0d", pick_pos_o, p.node));
          if (chosen_id_o !== p.id)
            report($sformatf("chosen_id %h, expected %h", chosen_id_o, p.id));
          if (last_chosen_o !== p.last)
            report($sformatf("last_chosen %b, expected %b", last_chosen_o, p.last));
          if (overflow_o !== p.ovf)
            report($sformatf("overflow %b, expected %b", overflow_o, p.ovf));
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Directed: extremes, no conflict, tie, winner, short and empty paths
  task automatic test_directed();
    send_entry(16'h0000, 16'h8000, 11'sd5, 1'b0, 1'b0);
    send_entry(16'h0000, 16'h8000, 11'h3FF, 1'b1, 1'b0);
    send_entry(16'hFFFF, 16'h7FFF, 11'sd5, 1'b1, 1'b0);
    send_entry(16'hAAAA, 16'h7FFF, 11'h3FF, 1'b1, 1'b0);
    send_entry(16'h5555, 16'h0100, DetNeg1, 1'b0, 1'b0);
    send_entry(16'h5555, 16'h0100, DetNone, 1'b0, 1'b0);
    send_entry(16'h5555, 16'h0100, 11'h3FF, 1'b1, 1'b0);
    send_entry(16'h1234, 16'h0200, DetNeg1, 1'b0, 1'b1);
    wait_drain();
    // Winner is a neighbour: chain of conflicts, rising scores
    send_entry(16'h0001, 16'h0010, 11'sd7, 1'b1, 1'b0);
    send_entry(16'h0002, 16'h0020, 11'sd7, 1'b0, 1'b0);
    send_entry(16'h0002, 16'h0020, 11'sd9, 1'b1, 1'b0);
    send_entry(16'h0003, 16'h0030, 11'sd8, 1'b0, 1'b0);
    send_entry(16'h0003, 16'h0030, 11'sd9, 1'b1, 1'b1);
    wait_drain();
    // Single hypothesis, one entry
    send_entry(16'hBEEF, 16'hFFFF, 11'sd1, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Too many frames and too many hypotheses
  task automatic test_overflow();
    send_hyp(16'h0100, 16'h0001, Frames + 3, 3, 1'b0);
    send_hyp(16'h0101, 16'h0002, 2, 3, 1'b1);
    wait_drain();
    for (int h = 0; h < Nodes + 3; h++)
      send_hyp(IdW'($urandom), ScoreW'($urandom), 1, 2, h == Nodes + 2);
    wait_drain();
  endtask

  // Random sets, mostly small, dense detections to make conflicts
  task automatic test_random(input int unsigned entries);
    int unsigned sent;
    int unsigned nh;
    int unsigned len;
    int unsigned dr;
    sent = 0;
    while (sent < entries) begin
      nh = ($urandom_range(9) == 0) ? $urandom_range(Nodes + 2, 20) : $urandom_range(8, 1);
      dr = ($urandom_range(3) == 0) ? 2047 : $urandom_range(6, 1);
      for (int h = 0; h < nh; h++) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(Frames + 2, 1) : $urandom_range(4, 1);
        send_hyp(IdW'($urandom), ScoreW'($urandom_range(3) == 0 ? $urandom : $urandom_range(8)),
                 len, dr, h == nh - 1);
        sent += len;
      end
      wait_drain();
    end
  endtask

  // Receiver held off for a fixed stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (int h = 0; h < 12; h++) send_hyp(IdW'(h), ScoreW'(h), 1, 2047, 1'b0);
    send_hyp(16'h00FF, 16'h0000, 1, 2047, 1'b1);
    send_entry(16'h0200, 16'h0001, 11'sd3, 1'b0, 1'b0);
    send_entry(16'h0200, 16'h0001, 11'sd3, 1'b1, 1'b1);
    wait_drain();
  endtask

  initial begin
    clear_set();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(60);
    send_idle_pct = 73;
    test_random(60);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    test_random(60);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    test_random(60);
    recv_stall_pct = 0;
    repeat (3000) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
